FILE: sv/spp_pkg.sv
// ---------------------------------------------------------------------------
// spp_pkg: shared types and codes for the SP-PIFO scheduler
// Result status and command codes, capacity reset value, sequencer states and the cell control bundle.
// ---------------------------------------------------------------------------
package spp_pkg;

  // result status codes
  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_DEQ   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // input command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // reset value of the capacity register
  localparam logic [6:0] CAP_RESET = 7'd60;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } spp_state_t;

  // update strobes broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
    logic push_down;
  } spp_cell_ctl_t;

endpackage

FILE: sv/spp_if.sv
// ---------------------------------------------------------------------------
// spp_if: channel interfaces of the SP-PIFO scheduler
// Request channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface spp_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] packet_tag;
  logic [15:0] packet_rank;

  modport source (output valid, command, packet_tag, packet_rank, input ready);
  modport sink   (input valid, command, packet_tag, packet_rank, output ready);
endinterface

interface spp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  fifo_index;
  logic [15:0] out_tag;
  logic [15:0] out_rank;

  modport source (output valid, status, fifo_index, out_tag, out_rank, input ready);
  modport sink   (input valid, status, fifo_index, out_tag, out_rank, output ready);
endinterface

FILE: sv/sp_pifo_scheduler_unit.sv
// ---------------------------------------------------------------------------
// sp_pifo_scheduler_unit: SP-PIFO scheduler top level
// Row of FIFO cells with rank bounds, shared packet store, result register.
// ---------------------------------------------------------------------------
//  channel  | dir | beat contents
//  in_if    | in  | command, packet_tag, packet_rank
//  out_if   | out | status, fifo_index, out_tag, out_rank
//  cfg_*    | in  | fifo_capacity (7 bits), written when cfg_we is high
//
// Each item passes S_IDLE then S_RESP: the decision, cell update and registered
// packet store read at the accept edge, then the result register loads in S_RESP.
// Reset (rst_n low, synchronous) clears bounds, pointers and counts at once;
// the packet store needs no clearing. A new beat is taken only while the
// result register is empty or being drained.
module sp_pifo_scheduler_unit
  import spp_pkg::*;
#(
  parameter int NUM_FIFOS  = 8,
  parameter int FIFO_DEPTH = 64,
  parameter int RANK_WIDTH = 16,
  parameter int TAG_WIDTH  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  spp_in_if.sink     in_if,
  spp_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int QW   = $clog2(NUM_FIFOS);
  localparam int PW   = $clog2(FIFO_DEPTH);
  localparam int CW   = $clog2(FIFO_DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam int AW   = QW + PW;
  localparam int DW   = TAG_WIDTH + RANK_WIDTH;

  spp_state_t state_r, state_nxt;

  logic [6:0]            cap_r;
  logic [RANK_WIDTH-1:0] rank;
  logic [TAG_WIDTH-1:0]  tag;
  logic [RANK_WIDTH-1:0] cost;
  spp_cell_ctl_t         ctl;
  logic                  accept;

  logic [NUM_FIFOS:0]    fit_chain;
  logic [NUM_FIFOS:0]    ne_chain;
  logic [NUM_FIFOS-1:0]  enq_sel_vec, deq_sel_vec;
  logic [RANK_WIDTH-1:0] bound_a [NUM_FIFOS];
  logic [PW-1:0]         head_a  [NUM_FIFOS];
  logic [PW-1:0]         tail_a  [NUM_FIFOS];
  logic [CW-1:0]         count_a [NUM_FIFOS];

  logic [QW-1:0]         enq_q, deq_q;
  logic [PW-1:0]         tail_sel, head_sel;
  logic [CW-1:0]         count_sel;
  logic [CMPW-1:0]       eff_cap;
  logic                  full;

  logic [DW-1:0]         mem [2**AW];
  logic [DW-1:0]         rdata_r;

  logic [1:0]            st_r, st_nxt;
  logic [QW-1:0]         q_r, q_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r;
  logic [2:0]            out_idx_r;
  logic [15:0]           out_tag_r, out_rank_r;

  // hold the capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign rank   = RANK_WIDTH'(in_if.packet_rank);
  assign tag    = TAG_WIDTH'(in_if.packet_tag);
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);

  // row of cells; fit chain runs down from the top index, non-empty chain up
  assign fit_chain[NUM_FIFOS] = 1'b0;
  assign ne_chain[0]          = 1'b0;

  for (genvar i = 0; i < NUM_FIFOS; i++) begin : g_cell
    spp_cell #(
      .RANK_WIDTH (RANK_WIDTH),
      .PW         (PW),
      .CW         (CW),
      .FIFO_DEPTH (FIFO_DEPTH),
      .IS_BASE    (i == 0)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .rank    (rank),
      .cost    (cost),
      .fit_in  (fit_chain[i+1]),
      .fit_out (fit_chain[i]),
      .ne_in   (ne_chain[i]),
      .ne_out  (ne_chain[i+1]),
      .enq_sel (enq_sel_vec[i]),
      .deq_sel (deq_sel_vec[i]),
      .bound   (bound_a[i]),
      .head    (head_a[i]),
      .tail    (tail_a[i]),
      .count   (count_a[i])
    );
  end

  // encode the chosen cells and pick their pointers
  always_comb begin
    enq_q     = '0;
    deq_q     = '0;
    tail_sel  = '0;
    head_sel  = '0;
    count_sel = '0;
    for (int i = 0; i < NUM_FIFOS; i++) begin
      if (enq_sel_vec[i]) begin
        enq_q     = enq_q | QW'(i);
        tail_sel  = tail_sel | tail_a[i];
        count_sel = count_sel | count_a[i];
      end
      if (deq_sel_vec[i]) begin
        deq_q    = deq_q | QW'(i);
        head_sel = head_sel | head_a[i];
      end
    end
  end

  // drop test against min(capacity, depth)
  always_comb begin
    eff_cap = (CMPW'(cap_r) < CMPW'(FIFO_DEPTH)) ? CMPW'(cap_r) : CMPW'(FIFO_DEPTH);
    full    = CMPW'(count_sel) >= eff_cap;
    cost    = bound_a[0] - rank;
  end

  // broadcast strobes and capture the outcome
  always_comb begin
    ctl.enq       = accept && (in_if.command == CMD_ENQ) && !full;
    ctl.deq       = accept && (in_if.command == CMD_DEQ) && ne_chain[NUM_FIFOS];
    ctl.push_down = !fit_chain[0];
    st_nxt        = st_r;
    q_nxt         = q_r;
    if (accept) begin
      if (in_if.command == CMD_ENQ) begin
        st_nxt = full ? ST_DROP : ST_ENQ;
        q_nxt  = enq_q;
      end else if (ne_chain[NUM_FIFOS]) begin
        st_nxt = ST_DEQ;
        q_nxt  = deq_q;
      end else begin
        st_nxt = ST_EMPTY;
        q_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    q_r  <= q_nxt;
  end

  // packet store: write on enqueue, registered read on dequeue
  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      mem[{enq_q, tail_sel}] <= {tag, rank};
    end
    rdata_r <= mem[{deq_q, head_sel}];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: load or drain the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_RESP:  out_valid_nxt = 1'b1;
      default: if (out_if.ready) out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP) begin
      out_status_r <= st_r;
      out_idx_r    <= 3'(q_r);
      if (st_r == ST_DEQ) begin
        out_tag_r  <= 16'(rdata_r[DW-1:RANK_WIDTH]);
        out_rank_r <= 16'(rdata_r[RANK_WIDTH-1:0]);
      end else begin
        out_tag_r  <= '0;
        out_rank_r <= '0;
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.fifo_index = out_idx_r;
  assign out_if.out_tag    = out_tag_r;
  assign out_if.out_rank   = out_rank_r;

`ifndef NO_ASSERTIONS
  // result register is free whenever a result is loaded
  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |-> !out_valid_r)
    else $error("result register overwritten");

  // exactly one cell takes an enqueue
  a_enq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(enq_sel_vec))
    else $error("enqueue selection not one-hot");

  // at most one cell serves a dequeue, and only when some FIFO holds a packet
  a_deq_sel: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(deq_sel_vec) && (ne_chain[NUM_FIFOS] == (deq_sel_vec != '0)))
    else $error("dequeue selection inconsistent");
`endif

endmodule

FILE: sv/spp_cell.sv
// ---------------------------------------------------------------------------
// spp_cell: one FIFO of the scheduler
// Holds rank bound, head, tail and fill count; joins the fit chain (from the
// lowest-priority end) and the non-empty chain (from the highest).
// ---------------------------------------------------------------------------
module spp_cell
  import spp_pkg::*;
#(
  parameter int RANK_WIDTH = 16,
  parameter int PW         = 6,
  parameter int CW         = 7,
  parameter int FIFO_DEPTH = 64,
  parameter bit IS_BASE    = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spp_cell_ctl_t         ctl,
  input  logic [RANK_WIDTH-1:0] rank,
  input  logic [RANK_WIDTH-1:0] cost,
  input  logic                  fit_in,
  output logic                  fit_out,
  input  logic                  ne_in,
  output logic                  ne_out,
  output logic                  enq_sel,
  output logic                  deq_sel,
  output logic [RANK_WIDTH-1:0] bound,
  output logic [PW-1:0]         head,
  output logic [PW-1:0]         tail,
  output logic [CW-1:0]         count
);

  logic [RANK_WIDTH-1:0] bound_r, bound_nxt;
  logic [PW-1:0]         head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  fits, nonempty;

  // chain links
  always_comb begin
    fits     = rank >= bound_r;
    nonempty = count_r != '0;
    fit_out  = fit_in | fits;
    ne_out   = ne_in | nonempty;
    // the base cell also takes the packet when no bound fits
    enq_sel  = IS_BASE ? !fit_in : (fits & !fit_in);
    deq_sel  = nonempty & !ne_in;
  end

  // next state
  always_comb begin
    bound_nxt = bound_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.enq && enq_sel) begin
      bound_nxt = rank;
      tail_nxt  = (tail_r == PW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (ctl.enq && ctl.push_down && !IS_BASE) begin
      bound_nxt = bound_r - cost;
    end
    if (ctl.deq && deq_sel) begin
      head_nxt  = (head_r == PW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      bound_r <= bound_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign bound = bound_r;
  assign head  = head_r;
  assign tail  = tail_r;
  assign count = count_r;

endmodule

FILE: tb/tb_sp_pifo_scheduler_unit.sv
// ---------------------------------------------------------------------------
// tb_sp_pifo_scheduler_unit: self-checking bench for the SP-PIFO scheduler
// Drives enqueue/dequeue beats with random idling and back-pressure, predicts
// each result beat from a behavioural model of bounds and FIFOs, and compares.
// ---------------------------------------------------------------------------
module tb_sp_pifo_scheduler_unit
  import spp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ    = 8;
  localparam int DEPTH = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  fifo_index;
    logic [15:0] tag;
    logic [15:0] rank;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  spp_in_if  in_if ();
  spp_out_if out_if ();

  sp_pifo_scheduler_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // model state
  logic [6:0]  capacity_q;
  logic [15:0] bound_q [NQ];
  logic [31:0] store_q [NQ][DEPTH];
  int          head_q [NQ];
  int          tail_q [NQ];
  int          fill_q [NQ];

  sched_result_t expected_results[$];
  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_drops = 0;
  int  n_empty = 0;
  bit  idle_send = 1'b1;   // random idling enabled on the input
  bit  idle_recv = 1'b1;   // random stalling enabled on the output
  int  hold_off = 0;       // cycles the receiver is to hold ready low

  // predict one result beat and advance the model
  function automatic sched_result_t predict_schedule(logic cmd, logic [15:0] tag,
                                                     logic [15:0] rank);
    sched_result_t r;
    int   q;
    bit   found;
    int   lim;
    logic [15:0] cost;
    r = '0;
    if (cmd == CMD_ENQ) begin
      q = 0;
      found = 1'b0;
      for (int i = NQ - 1; i >= 0; i--) begin
        if (!found && rank >= bound_q[i]) begin
          q = i;
          found = 1'b1;
        end
      end
      lim = (capacity_q < DEPTH) ? capacity_q : DEPTH;
      r.fifo_index = q[2:0];
      if (fill_q[q] >= lim) begin
        r.status = ST_DROP;
        return r;
      end
      store_q[q][tail_q[q]] = {tag, rank};
      tail_q[q] = (tail_q[q] + 1) % DEPTH;
      fill_q[q]++;
      if (found) begin
        bound_q[q] = rank;
      end else begin
        cost = bound_q[0] - rank;
        bound_q[0] = rank;
        for (int i = 1; i < NQ; i++) bound_q[i] = bound_q[i] - cost;
      end
      r.status = ST_ENQ;
      return r;
    end
    for (int i = 0; i < NQ; i++) begin
      if (fill_q[i] != 0) begin
        r.status = ST_DEQ;
        r.fifo_index = i[2:0];
        {r.tag, r.rank} = store_q[i][head_q[i]];
        head_q[i] = (head_q[i] + 1) % DEPTH;
        fill_q[i]--;
        return r;
      end
    end
    r.status = ST_EMPTY;
    return r;
  endfunction

  // offer one beat, with optional random idling first
  task automatic send_request(logic cmd, logic [15:0] tag, logic [15:0] rank);
    if (idle_send) begin
      while ($urandom_range(99) < 25) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.packet_tag  <= tag;
    in_if.packet_rank <= rank;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(predict_schedule(cmd, tag, rank));
    n_sent++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_q = value;
  endtask

  task automatic enq(logic [15:0] tag, logic [15:0] rank);
    send_request(CMD_ENQ, tag, rank);
  endtask

  task automatic deq();
    send_request(CMD_DEQ, 16'($urandom), 16'($urandom));
  endtask

  // empty queue, push-up, ordering
  task automatic test_directed();
    deq();
    enq(16'h0000, 16'h0000);
    enq(16'hFFFF, 16'hFFFF);
    enq(16'h1234, 16'h0100);
    enq(16'hA5A5, 16'h0050);
    enq(16'h5A5A, 16'h0001);
    enq(16'h8001, 16'h8000);
    enq(16'h7FFE, 16'h7FFF);
    repeat (8) deq();
  endtask

  // capacity of one, zero (all dropped), and above the FIFO depth
  task automatic test_capacity_extremes();
    write_capacity(7'd1);
    repeat (6) enq(16'($urandom), 16'($urandom_range(3)));
    repeat (4) deq();
    write_capacity(7'd0);
    repeat (3) enq(16'($urandom), 16'($urandom));
    deq();
    write_capacity(7'd127);
    repeat (3) deq();
  endtask

  // fill one FIFO to the depth so the store pointers wrap
  task automatic test_fill_wrap();
    write_capacity(7'd64);
    for (int i = 0; i < 66; i++) enq(i[15:0], 16'hFFFF);
    for (int i = 0; i < 40; i++) deq();
    for (int i = 0; i < 30; i++) enq(i[15:0] ^ 16'h5555, 16'hFFFF);
    while (fill_total() != 0) deq();
    deq();
  endtask

  function automatic int fill_total();
    int s;
    s = 0;
    for (int i = 0; i < NQ; i++) s += fill_q[i];
    return s;
  endfunction

  // mixed random traffic at several capacities
  task automatic test_random(int count, logic [6:0] cap);
    write_capacity(cap);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 55) enq(16'($urandom), $urandom_range(1) ? 16'($urandom)
                                          : 16'($urandom_range(64)));
      else deq();
    end
  endtask

  // long receiver hold-off so the block stalls the input
  task automatic test_backpressure();
    idle_send = 1'b0;
    hold_off = 60;
    for (int i = 0; i < 20; i++) enq(16'($urandom), 16'($urandom));
    wait_drained();
    idle_send = 1'b1;
    for (int i = 0; i < 20; i++) deq();
  endtask

  // stimulus
  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_ENQ;
    in_if.packet_tag = '0;
    in_if.packet_rank = '0;
    capacity_q = CAP_RESET;
    for (int i = 0; i < NQ; i++) begin
      bound_q[i] = '0; head_q[i] = 0; tail_q[i] = 0; fill_q[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity_extremes();
    test_fill_wrap();
    test_backpressure();
    test_random(150, 7'd3);
    idle_send = 1'b0;
    idle_recv = 1'b0;
    test_random(100, 7'd60);
    idle_send = 1'b1;
    idle_recv = 1'b1;
    test_random(50, 7'd8);
    test_random(50, 7'd1);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d beats (%0d drops, %0d empty dequeues), capacities 0..127,",
             n_sent, n_drops, n_empty);
    $display("push-up and push-down bounds, FIFO wrap and long output stalls.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver ready: random stalls plus the counted hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
        hold_off--;
      end else begin
        out_if.ready <= !(idle_recv && $urandom_range(99) < 25);
      end
    end
  end

  // check every accepted result beat
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d", $realtime, out_if.status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (exp_r.status == ST_DROP) n_drops++;
        if (exp_r.status == ST_EMPTY) n_empty++;
        if (out_if.status !== exp_r.status || out_if.fifo_index !== exp_r.fifo_index
            || out_if.out_tag !== exp_r.tag || out_if.out_rank !== exp_r.rank) begin
          $display("%0t: mismatch expected st=%0d q=%0d tag=%h rank=%h",
                   $realtime, exp_r.status, exp_r.fifo_index, exp_r.tag, exp_r.rank);
          $display("%0t:          got      st=%0d q=%0d tag=%h rank=%h",
                   $realtime, out_if.status, out_if.fifo_index, out_if.out_tag,
                   out_if.out_rank);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
